// ===== rtl/brlre_pkg.sv =====
// ----------------------------------------------------------------------------
// brlre_pkg
// Shared types and constants for the binary run-length Rice encoder.
// ----------------------------------------------------------------------------
package brlre_pkg;

    // Largest Rice parameter; run counter width follows from it
    localparam int MAX_K     = 15;
    localparam int K_W       = 4;
    localparam int RUN_W     = MAX_K;
    localparam int MOD_W     = RUN_W + 1;

    // Longest code burst from one source bit: one, zero, k bits, end bit
    localparam int CODE_MAX  = MAX_K + 3;
    localparam int CNT_W     = $clog2(CODE_MAX + 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = K_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RICE_K    = 2'd0,
        CFG_MPS_BIT   = 2'd1,
        CFG_DIFF_MODE = 2'd2
    } t_cfg_index;

    // Source word
    typedef struct packed {
        logic in_bit;
        logic stream_end;
    } t_in_word;

    // Code word
    typedef struct packed {
        logic code_bit;
        logic burst_last;
    } t_out_word;

    // Burst command: bits right-aligned, bits[len-1] goes out first
    typedef struct packed {
        logic [CODE_MAX-1:0] bits;
        logic [CNT_W-1:0]    len;
    } t_cmd;

endpackage

// ===== rtl/brlre_front.sv =====
// ----------------------------------------------------------------------------
// brlre_front
// Holds configuration and run state, classifies each source bit as MPS or
// LPS and builds the whole code burst it causes as one command.
// ----------------------------------------------------------------------------
module brlre_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [brlre_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [brlre_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_accept,
    input  brlre_pkg::t_in_word                i_word,
    output logic                               o_push,
    output brlre_pkg::t_cmd                    o_cmd
);

    logic [brlre_pkg::K_W-1:0]   r_rice_k;
    logic                        r_mps_bit;
    logic                        r_diff_mode;
    logic [brlre_pkg::RUN_W-1:0] r_run;
    logic                        r_prev_raw;
    logic                        r_started;

    logic [brlre_pkg::K_W-1:0]      k_eff;
    logic [brlre_pkg::MOD_W-1:0]    run_next;
    logic [brlre_pkg::MOD_W-1:0]    modulus;
    logic                           coded;
    logic                           is_mps;
    logic                           grp_done;
    logic [brlre_pkg::RUN_W-1:0]    run_mps;
    logic                           has_one;
    logic                           has_body;
    logic [brlre_pkg::RUN_W-1:0]    rem_val;
    logic [brlre_pkg::RUN_W-1:0]    rem_mask;
    logic [brlre_pkg::CNT_W-1:0]    body_len;
    logic [brlre_pkg::CODE_MAX-1:0] v1;
    logic [brlre_pkg::CODE_MAX-1:0] v2;
    logic [brlre_pkg::CODE_MAX-1:0] v3;
    logic [brlre_pkg::CNT_W-1:0]    l1;
    logic [brlre_pkg::CNT_W-1:0]    l2;
    logic [brlre_pkg::CNT_W-1:0]    l3;

    // Classify the source bit
    always_comb begin
        k_eff    = (r_rice_k > brlre_pkg::K_W'(brlre_pkg::MAX_K))
                   ? brlre_pkg::K_W'(brlre_pkg::MAX_K) : r_rice_k;
        modulus  = brlre_pkg::MOD_W'(1) << k_eff;
        run_next = {1'b0, r_run} + brlre_pkg::MOD_W'(1);
        coded    = (r_diff_mode && r_started) ? (i_word.in_bit ^ r_prev_raw)
                                              : i_word.in_bit;
        is_mps   = (coded == r_mps_bit);
        grp_done = (run_next >= modulus);
        run_mps  = grp_done ? '0 : run_next[brlre_pkg::RUN_W-1:0];
        has_one  = is_mps && grp_done;
        has_body = !is_mps || i_word.stream_end;
        // LPS codes the old run; final MPS codes the updated run
        rem_val  = is_mps ? run_mps : r_run;
        rem_mask = brlre_pkg::RUN_W'((modulus - brlre_pkg::MOD_W'(1)));
        body_len = brlre_pkg::CNT_W'(k_eff) + brlre_pkg::CNT_W'(1);
    end

    // Assemble burst: optional one, zero plus remainder, optional end bit
    always_comb begin
        v1 = has_one ? brlre_pkg::CODE_MAX'(1) : '0;
        l1 = has_one ? brlre_pkg::CNT_W'(1) : '0;
        if (has_body) begin
            v2 = (v1 << body_len) | brlre_pkg::CODE_MAX'(rem_val & rem_mask);
            l2 = l1 + body_len;
        end else begin
            v2 = v1;
            l2 = l1;
        end
        if (i_word.stream_end) begin
            v3 = {v2[brlre_pkg::CODE_MAX-2:0], !is_mps};
            l3 = l2 + brlre_pkg::CNT_W'(1);
        end else begin
            v3 = v2;
            l3 = l2;
        end
    end

    assign o_cmd.bits = v3;
    assign o_cmd.len  = l3;
    assign o_push     = i_accept && (l3 != '0);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rice_k    <= '0;
            r_mps_bit   <= 1'b1;
            r_diff_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                brlre_pkg::CFG_RICE_K:    r_rice_k    <= i_cfg_data;
                brlre_pkg::CFG_MPS_BIT:   r_mps_bit   <= i_cfg_data[0];
                brlre_pkg::CFG_DIFF_MODE: r_diff_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Run state; end of stream starts a fresh stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= '0;
            r_prev_raw <= 1'b0;
            r_started  <= 1'b0;
        end else if (i_accept) begin
            if (i_word.stream_end) begin
                r_run      <= '0;
                r_prev_raw <= 1'b0;
                r_started  <= 1'b0;
            end else begin
                r_run      <= is_mps ? run_mps : '0;
                r_prev_raw <= i_word.in_bit;
                r_started  <= 1'b1;
            end
        end
    end

    // Assertions
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_cmd.len <= brlre_pkg::CNT_W'(brlre_pkg::CODE_MAX)))
        else $error("burst longer than maximum");
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_word.stream_end) |=> (r_run == '0 && !r_started))
        else $error("stream end did not clear run state");
    a_lps_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !is_mps) |-> o_push)
        else $error("LPS bit produced no code");

endmodule

// ===== rtl/brlre_queue.sv =====
// ----------------------------------------------------------------------------
// brlre_queue
// Short command FIFO between the front and the back serializer.
// ----------------------------------------------------------------------------
module brlre_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  brlre_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output brlre_pkg::t_cmd o_cmd
);

    brlre_pkg::t_cmd                 r_mem [brlre_pkg::QUEUE_DEPTH];
    logic [brlre_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [brlre_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [brlre_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == brlre_pkg::QCNT_W'(brlre_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + brlre_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + brlre_pkg::QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + brlre_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - brlre_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Assertions
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= brlre_pkg::QCNT_W'(brlre_pkg::QUEUE_DEPTH))
        else $error("fill count out of range");

endmodule

// ===== rtl/brlre_back.sv =====
// ----------------------------------------------------------------------------
// brlre_back
// Serializes burst commands to an output register, one bit per cycle unless stalled.
// ----------------------------------------------------------------------------
module brlre_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  brlre_pkg::t_cmd      i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output brlre_pkg::t_out_word o_out_word
);

    logic [brlre_pkg::CODE_MAX-1:0] r_bits;
    logic [brlre_pkg::CNT_W-1:0]    r_cnt;
    logic                           r_out_valid;
    brlre_pkg::t_out_word           r_out_word;

    logic                        load_out;
    logic                        emit;
    logic [brlre_pkg::CNT_W-1:0] idx;

    // Output register frees up when empty or taken
    assign load_out  = !r_out_valid || i_out_ready;
    assign emit      = load_out && (r_cnt != '0);
    assign idx       = r_cnt - brlre_pkg::CNT_W'(1);
    // Fetch next command when idle or as the current one sends its last bit
    assign o_cmd_pop = i_cmd_valid &&
                       ((r_cnt == '0) || ((r_cnt == brlre_pkg::CNT_W'(1)) && load_out));

    // Shift state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_cmd_pop) begin
            r_cnt <= i_cmd.len;
        end else if (emit) begin
            r_cnt <= idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_bits <= i_cmd.bits;
        end
    end

    // Output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word.code_bit   <= r_bits[idx];
            r_out_word.burst_last <= (r_cnt == brlre_pkg::CNT_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Assertions
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= brlre_pkg::CNT_W'(brlre_pkg::CODE_MAX))
        else $error("bit count out of range");
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_cnt == brlre_pkg::CNT_W'(1)) |=> r_out_word.burst_last)
        else $error("burst end not flagged");
    a_pop_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && r_cnt != '0) |-> emit)
        else $error("command fetched over unsent bits");

endmodule

// ===== rtl/binary_run_length_rice_encoder.sv =====
// ----------------------------------------------------------------------------
// binary_run_length_rice_encoder
// Run-length Golomb-Rice coder of a binary source, bit-serial code output.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_in_word  (t_in_word)
//   out      output     o_out_valid / i_out_ready  o_out_word (t_out_word)
//   cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// One source word is taken per cycle while the FIFO has room; its code burst
// (0 to k+3 bits) is queued in a 4-entry command FIFO and sent one code word
// per cycle while the output is taken. Sustained input rate is bounded by the
// serializer: one code bit per cycle. o_in_ready drops only while the command FIFO is full.
// Reset is synchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_run_length_rice_encoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  brlre_pkg::t_in_word                i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output brlre_pkg::t_out_word               o_out_word,
    input  logic                               i_cfg_we,
    input  logic [brlre_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [brlre_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic            in_accept;
    logic            push;
    logic            full;
    logic            pop;
    logic            q_valid;
    brlre_pkg::t_cmd f_cmd;
    brlre_pkg::t_cmd q_cmd;

    assign o_in_ready = !full;
    assign in_accept  = i_in_valid && !full;

    // Front: classify and build bursts
    brlre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_word      (i_in_word),
        .o_push      (push),
        .o_cmd       (f_cmd)
    );

    // Command FIFO
    brlre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back: bit serializer
    brlre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== tb/tb_binary_run_length_rice_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_binary_run_length_rice_encoder
// Self-checking bench for the run-length Rice encoder. A directed table covers
// the corner cases: group completion at k=0, LPS remainders, stream
// terminators, k lowered below a pending run, and difference mode. Random
// streams follow, mostly MPS runs broken by LPS bits, under several register
// settings and three idle patterns. One long output hold-off fills the block.
// Every code word is checked against typed table bits or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_binary_run_length_rice_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HI         = 6;
    localparam int CLK_LO         = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 10;    // coder pipeline plus FIFO, with margin
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_WORDS    = 25;
    localparam int NUM_ROWS       = 28;

    // One source word waiting to be sent; as_coded asks for a coded value,
    // turned into a raw bit once the previous word has been taken
    typedef struct packed {
        logic                          as_coded;
        logic                          value;
        logic                          last;
        logic                          typed;
        logic [4:0]                    exp_len;
        logic [brlre_pkg::CODE_MAX-1:0] exp_bits;
    } t_src_plan;

    // Directed table row: a register write or a source word
    typedef struct packed {
        logic                             is_cfg;
        brlre_pkg::t_cfg_index            idx;
        logic [brlre_pkg::CFG_DATA_W-1:0] data;
        logic                             in_bit;
        logic                             last;
        logic                             typed;
        logic [4:0]                       exp_len;
        logic [brlre_pkg::CODE_MAX-1:0]   exp_bits;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [0:NUM_ROWS-1] = '{
        // after reset: k=0, MPS=1, raw bits
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b0, 1'b1, 5'd1, 18'b1},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b0, 1'b0, 1'b1, 5'd1, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b1, 1'b1, 5'd3, 18'b100},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b0, 1'b1, 1'b1, 5'd2, 18'b01},
        // widest remainder
        '{1'b1, brlre_pkg::CFG_RICE_K,    4'd15, 1'b0, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b0, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b0, 1'b0, 5'd0, 18'b0},
        // k lowered under a pending run of three: next MPS overshoots
        '{1'b1, brlre_pkg::CFG_RICE_K,    4'd1,  1'b0, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b1, 1'b0, 5'd0, 18'b0},
        // long MPS terminator
        '{1'b1, brlre_pkg::CFG_RICE_K,    4'd15, 1'b0, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b1, 1'b0, 5'd0, 18'b0},
        // zero as MPS
        '{1'b1, brlre_pkg::CFG_MPS_BIT,   4'd0,  1'b0, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b0, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b1, 1'b0, 5'd0, 18'b0},
        // difference mode; first bit of each stream passes unchanged
        '{1'b1, brlre_pkg::CFG_DIFF_MODE, 4'd1,  1'b0, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b0, 1'b0, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b0, 1'b1, 1'b0, 5'd0, 18'b0},
        '{1'b0, brlre_pkg::CFG_RICE_K,    4'd0,  1'b1, 1'b1, 1'b0, 5'd0, 18'b0}
    };

    // DUT signals
    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    brlre_pkg::t_in_word              in_word   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    brlre_pkg::t_out_word             out_word;
    logic                             cfg_we    = 1'b0;
    logic [brlre_pkg::CFG_IDX_W-1:0]  cfg_index = brlre_pkg::CFG_RICE_K;
    logic [brlre_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of registers and coder state
    logic [brlre_pkg::K_W-1:0]   k_cfg     = '0;
    logic                        mps_cfg   = 1'b1;
    logic                        diff_cfg  = 1'b0;
    logic [brlre_pkg::RUN_W-1:0] run_count = '0;
    logic                        prev_raw  = 1'b0;
    logic                        started   = 1'b0;

    brlre_pkg::t_out_word burst_q[$];
    brlre_pkg::t_out_word expected_code_q[$];
    t_src_plan            plan_q[$];
    t_src_plan            cur_plan;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    int errors        = 0;
    int words_in      = 0;
    int streams_done  = 0;
    int code_words    = 0;
    int stall_cycles  = 0;

    binary_run_length_rice_encoder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Clock
    always begin
        #CLK_HI clk = 1'b1;
        #CLK_LO clk = 1'b0;
    end

    // --------------------------------------------------------------------
    // Predictor
    // --------------------------------------------------------------------
    task automatic emit_code_bit(input logic b);
        brlre_pkg::t_out_word cw;
        cw.code_bit   = b;
        cw.burst_last = 1'b0;
        burst_q = {burst_q, cw};
    endtask

    // Low k bits of the run, MSB first
    task automatic emit_run_bits(input int k);
        for (int i = k; i > 0; i--)
            emit_code_bit(run_count[i-1]);
    endtask

    task automatic predict_code_burst(input brlre_pkg::t_in_word w);
        int          k;
        int unsigned next_run;
        logic        coded;
        logic        is_mps;
        burst_q.delete();
        k      = (k_cfg > brlre_pkg::MAX_K) ? brlre_pkg::MAX_K : int'(k_cfg);
        coded  = (diff_cfg && started) ? (w.in_bit ^ prev_raw) : w.in_bit;
        is_mps = (coded == mps_cfg);

        if (is_mps) begin
            next_run = run_count + 1;
            if (next_run >= (32'd1 << k)) begin
                emit_code_bit(1'b1);
                run_count = '0;
            end else begin
                run_count = next_run[brlre_pkg::RUN_W-1:0];
            end
        end else begin
            emit_code_bit(1'b0);
            emit_run_bits(k);
            run_count = '0;
        end
        prev_raw = w.in_bit;
        started  = 1'b1;

        // stream terminator, then a fresh stream
        if (w.stream_end) begin
            if (is_mps) begin
                emit_code_bit(1'b0);
                emit_run_bits(k);
                emit_code_bit(1'b0);
            end else begin
                emit_code_bit(1'b1);
            end
            run_count = '0;
            prev_raw  = 1'b0;
            started   = 1'b0;
        end

        if (burst_q.size() != 0)
            burst_q[burst_q.size() - 1].burst_last = 1'b1;
    endtask

    // Accepted source word: queue its code burst, typed or predicted
    task automatic take_source_word(input brlre_pkg::t_in_word w, input t_src_plan p);
        brlre_pkg::t_out_word cw;
        predict_code_burst(w);
        if (p.typed) begin
            burst_q.delete();
            for (int i = int'(p.exp_len) - 1; i >= 0; i--) begin
                cw.code_bit   = p.exp_bits[i];
                cw.burst_last = (i == 0);
                burst_q = {burst_q, cw};
            end
        end
        foreach (burst_q[i])
            expected_code_q = {expected_code_q, burst_q[i]};
        words_in++;
        if (w.stream_end)
            streams_done++;
    endtask

    // --------------------------------------------------------------------
    // Source side
    // --------------------------------------------------------------------
    always @(posedge clk) begin : source_drive
        logic                taken;
        t_src_plan           plan;
        brlre_pkg::t_in_word w;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken = in_valid && in_ready;
            if (taken)
                take_source_word(in_word, cur_plan);
            if (in_valid && !in_ready)
                stall_cycles++;
            // next word only once the current one is gone
            if (!in_valid || taken) begin
                if (plan_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    plan = plan_q.pop_front();
                    if (plan.as_coded && diff_cfg && started)
                        w.in_bit = plan.value ^ prev_raw;
                    else
                        w.in_bit = plan.value;
                    w.stream_end = plan.last;
                    cur_plan     = plan;
                    in_valid    <= 1'b1;
                    in_word     <= w;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // Code side: random ready, long hold-off on request
    // --------------------------------------------------------------------
    always @(posedge clk) begin : sink_drive
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Code word check against the oldest expectation
    always @(posedge clk) begin : code_check
        brlre_pkg::t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_code_q.size() == 0) begin
                errors++;
                $display("%0t: code word with none expected: code_bit=%0b burst_last=%0b",
                         $time, out_word.code_bit, out_word.burst_last);
            end else begin
                want = expected_code_q.pop_front();
                code_words++;
                if (out_word.code_bit !== want.code_bit) begin
                    errors++;
                    $display("%0t: code_bit mismatch: expected %0b, got %0b",
                             $time, want.code_bit, out_word.code_bit);
                end
                if (out_word.burst_last !== want.burst_last) begin
                    errors++;
                    $display("%0t: burst_last mismatch: expected %0b, got %0b",
                             $time, want.burst_last, out_word.burst_last);
                end
            end
        end
    end

    // Watchdog: too long without any word moving
    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d code words outstanding",
                     $time, WATCHDOG_LIMIT, expected_code_q.size());
            $display("binary_run_length_rice_encoder test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // --------------------------------------------------------------------
    // Stimulus helpers
    // --------------------------------------------------------------------
    task automatic wait_idle();
        while (plan_q.size() != 0 || in_valid || expected_code_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input brlre_pkg::t_cfg_index idx,
                             input logic [brlre_pkg::CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            brlre_pkg::CFG_RICE_K:    k_cfg    = val;
            brlre_pkg::CFG_MPS_BIT:   mps_cfg  = val[0];
            brlre_pkg::CFG_DIFF_MODE: diff_cfg = val[0];
            default: ;
        endcase
    endtask

    task automatic queue_plan(input t_src_plan p);
        while (plan_q.size() >= 2)
            @(posedge clk);
        plan_q = {plan_q, p};
    endtask

    // Mostly MPS runs broken by LPS bits; some raw noise
    function automatic t_src_plan random_plan();
        t_src_plan p;
        int        roll;
        p    = '0;
        roll = $urandom_range(99);
        if (roll < 70) begin
            p.as_coded = 1'b1;
            p.value    = mps_cfg;
        end else if (roll < 88) begin
            p.as_coded = 1'b1;
            p.value    = ~mps_cfg;
        end else begin
            p.value = 1'($urandom_range(1));
        end
        p.last = ($urandom_range(9) == 0);
        return p;
    endfunction

    // --------------------------------------------------------------------
    // Main sequence
    // --------------------------------------------------------------------
    initial begin : stimulus
        t_src_plan p;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (DIR_ROWS[r].is_cfg) begin
                write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
            end else begin
                p          = '0;
                p.value    = DIR_ROWS[r].in_bit;
                p.last     = DIR_ROWS[r].last;
                p.typed    = DIR_ROWS[r].typed;
                p.exp_len  = DIR_ROWS[r].exp_len;
                p.exp_bits = DIR_ROWS[r].exp_bits;
                queue_plan(p);
            end
        end

        // random phases: two per idle pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph / 2)
                0:       begin send_idle_pct = 28; recv_idle_pct = 77; end
                1:       begin send_idle_pct = 77; recv_idle_pct = 28; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (ph)
                0: begin
                    write_reg(brlre_pkg::CFG_RICE_K, 4'd15);
                    write_reg(brlre_pkg::CFG_MPS_BIT, 4'd0);
                    write_reg(brlre_pkg::CFG_DIFF_MODE, 4'd0);
                end
                1: begin
                    write_reg(brlre_pkg::CFG_RICE_K, 4'd0);
                    write_reg(brlre_pkg::CFG_MPS_BIT, 4'd1);
                    write_reg(brlre_pkg::CFG_DIFF_MODE, 4'd1);
                end
                2: begin
                    write_reg(brlre_pkg::CFG_RICE_K, 4'($urandom_range(1, 14)));
                    write_reg(brlre_pkg::CFG_MPS_BIT, 4'd1);
                    write_reg(brlre_pkg::CFG_DIFF_MODE, 4'd0);
                end
                3: begin
                    write_reg(brlre_pkg::CFG_RICE_K, 4'd15);
                    write_reg(brlre_pkg::CFG_MPS_BIT, 4'd1);
                    write_reg(brlre_pkg::CFG_DIFF_MODE, 4'd1);
                end
                4: begin
                    write_reg(brlre_pkg::CFG_RICE_K, 4'd0);
                    write_reg(brlre_pkg::CFG_MPS_BIT, 4'd0);
                    write_reg(brlre_pkg::CFG_DIFF_MODE, 4'd0);
                end
                default: begin
                    write_reg(brlre_pkg::CFG_RICE_K, 4'($urandom_range(15)));
                    write_reg(brlre_pkg::CFG_MPS_BIT, 4'($urandom_range(1)));
                    write_reg(brlre_pkg::CFG_DIFF_MODE, 4'($urandom_range(1)));
                end
            endcase
            // output hold-off while words keep coming: fills the FIFO
            if (ph == 4)
                hold_requests++;
            for (int i = 0; i < PHASE_WORDS; i++)
                queue_plan(random_plan());
        end

        wait_idle();
        $display("Coded %0d source words in %0d closed streams into %0d code words.",
                 words_in, streams_done, code_words);
        $display("Six register settings, three idle patterns; input stalled %0d cycles.",
                 stall_cycles);
        if (errors == 0 && expected_code_q.size() == 0) begin
            $display("binary_run_length_rice_encoder test passed");
        end else begin
            $display("binary_run_length_rice_encoder test failed");
        end
        $finish;
    end

endmodule
